// ----- src/sst_pkg.sv -----
// Shared types and codes for the sorted set table.
// No dependencies; imported by sst_out, sst_seq and the core, not by sst_mem.
`timescale 1ns / 1ps
`default_nettype none

package sst_pkg;

  // Operation codes of the input item
  localparam logic [2:0] FUNC_ADD    = 3'd0;
  localparam logic [2:0] FUNC_REMOVE = 3'd1;
  localparam logic [2:0] FUNC_TEST   = 3'd2;
  localparam logic [2:0] FUNC_READ   = 3'd3;
  localparam logic [2:0] FUNC_LIST   = 3'd4;

  // Status codes of a result item
  localparam logic [1:0] STAT_DONE   = 2'd0;
  localparam logic [1:0] STAT_NOCHG  = 2'd1;
  localparam logic [1:0] STAT_FULL   = 2'd2;
  localparam logic [1:0] STAT_EMPTY  = 2'd3;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] value;
  } sst_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               hit;
    logic signed [31:0] data;
    logic [4:0]         count;
    logic               is_empty;
    logic               last;
  } sst_out_t;

endpackage

`default_nettype wire

// ----- src/sst_mem.sv -----
// Element store: one write port, one registered read port.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module sst_mem #(
  parameter int DEPTH = 16,
  parameter int EW    = 32,
  parameter int AW    = 4
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic [EW-1:0]      rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [EW-1:0] wr_data
);

  logic [EW-1:0] mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one entry into the output register; hold it when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- src/sst_out.sv -----
// Result register with valid/stall handshake toward the consumer.
// Depends on sst_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module sst_out
  import sst_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     ld,
  input  wire sst_out_t res,
  output logic          free,
  output logic          out_valid,
  input  wire logic     out_stall,
  output sst_out_t      out_item
);

  logic valid_r;
  logic valid_nxt;

  // Slot is free when empty or when its transfer completes this cycle
  assign free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (ld) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load payload only on a new result; hold it while stalled
  always_ff @(posedge clk) begin
    if (ld) begin
      out_item <= res;
    end
  end

  assign out_valid = valid_r;

endmodule

`default_nettype wire

// ----- src/sst_seq.sv -----
// Sequencer: scans the store one entry per cycle, shifts entries on add
// and remove, and emits results. Depends on sst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sst_seq
  import sst_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int EW       = 32,
  parameter int AW       = 4,
  parameter int CW       = 5
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire sst_in_t       in_item,
  output logic               rd_en,
  output logic [AW-1:0]      rd_addr,
  input  wire logic [EW-1:0] rd_data,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic [EW-1:0]      wr_data,
  input  wire logic          out_free,
  output logic               ld,
  output sst_out_t           res
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_TAIL = 5'b00100,
    S_LIST = 5'b01000,
    S_RESP = 5'b10000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          flag_r, flag_nxt;
  logic          single_r, single_nxt;
  logic [2:0]    func_r, func_nxt;
  logic [EW-1:0] e_r, e_nxt;
  logic [EW-1:0] carry_r, carry_nxt;
  logic [1:0]    st_r, st_nxt;
  logic          hit_r, hit_nxt;

  logic              accept;
  logic [EW+31:0]    val_sx;
  logic [EW+31:0]    rd_sx;
  logic [CW+4:0]     cnt_ext;
  logic              eq, lt, gt;
  logic              is_last;
  logic              full;
  logic              empty;

  assign accept  = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);

  // Bring the 32-bit input to element width, and an element back to 32 bits
  assign val_sx  = {{EW{in_item.value[31]}}, in_item.value};
  assign rd_sx   = {{32{rd_data[EW-1]}}, rd_data};
  assign cnt_ext = {5'b0, count_r};

  // Compare the entry just read against the operand
  assign eq      = (rd_data == e_r);
  assign lt      = ($signed(rd_data) < $signed(e_r));
  assign gt      = !eq && !lt;
  assign is_last = ((CW'(idx_r) + CW'(1)) == count_r);
  assign full    = (count_r == CW'(CAPACITY));
  assign empty   = (count_r == '0);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    flag_nxt   = flag_r;
    single_nxt = single_r;
    func_nxt   = func_r;
    e_nxt      = e_r;
    carry_nxt  = carry_r;
    st_nxt     = st_r;
    hit_nxt    = hit_r;
    rd_en      = 1'b0;
    rd_addr    = idx_r + AW'(1);
    wr_en      = 1'b0;
    wr_addr    = idx_r;
    wr_data    = carry_r;
    ld         = 1'b0;
    res        = '0;
    res.count    = cnt_ext[4:0];
    res.is_empty = empty;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          func_nxt   = in_item.func;
          e_nxt      = val_sx[EW-1:0];
          flag_nxt   = 1'b0;
          hit_nxt    = 1'b0;
          idx_nxt    = '0;
          rd_addr    = '0;
          single_nxt = (in_item.func == FUNC_READ);
          case (in_item.func)
            FUNC_ADD: begin
              if (empty) begin
                // First element goes straight to entry zero
                wr_en     = 1'b1;
                wr_addr   = '0;
                wr_data   = val_sx[EW-1:0];
                count_nxt = CW'(1);
                st_nxt    = STAT_DONE;
                state_nxt = S_RESP;
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_SCAN;
              end
            end
            FUNC_REMOVE, FUNC_TEST: begin
              if (empty) begin
                st_nxt    = (in_item.func == FUNC_TEST) ? STAT_DONE : STAT_NOCHG;
                state_nxt = S_RESP;
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_SCAN;
              end
            end
            FUNC_READ, FUNC_LIST: begin
              if (empty) begin
                st_nxt    = STAT_EMPTY;
                state_nxt = S_RESP;
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_LIST;
              end
            end
            default: begin
              st_nxt    = STAT_NOCHG;
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Advance to the next entry unless this step finishes the scan
        case (func_r)
          FUNC_ADD: begin
            if (!flag_r) begin
              if (eq) begin
                st_nxt    = STAT_NOCHG;
                state_nxt = S_RESP;
              end else if (gt) begin
                if (full) begin
                  st_nxt    = STAT_FULL;
                  state_nxt = S_RESP;
                end else begin
                  wr_en     = 1'b1;
                  wr_data   = e_r;
                  carry_nxt = rd_data;
                  flag_nxt  = 1'b1;
                  if (is_last) begin
                    state_nxt = S_TAIL;
                  end else begin
                    rd_en   = 1'b1;
                    idx_nxt = idx_r + AW'(1);
                  end
                end
              end else if (is_last) begin
                if (full) begin
                  st_nxt    = STAT_FULL;
                  state_nxt = S_RESP;
                end else begin
                  carry_nxt = e_r;
                  state_nxt = S_TAIL;
                end
              end else begin
                rd_en   = 1'b1;
                idx_nxt = idx_r + AW'(1);
              end
            end else begin
              // Shift up: write the held entry, hold the one just read
              wr_en     = 1'b1;
              carry_nxt = rd_data;
              if (is_last) begin
                state_nxt = S_TAIL;
              end else begin
                rd_en   = 1'b1;
                idx_nxt = idx_r + AW'(1);
              end
            end
          end
          FUNC_REMOVE: begin
            if (flag_r) begin
              // Shift down over the removed entry
              wr_en   = 1'b1;
              wr_addr = idx_r - AW'(1);
              wr_data = rd_data;
            end else if (eq) begin
              flag_nxt = 1'b1;
            end
            if (!flag_r && gt) begin
              st_nxt    = STAT_NOCHG;
              state_nxt = S_RESP;
            end else if (is_last) begin
              if (flag_r || eq) begin
                count_nxt = count_r - CW'(1);
                st_nxt    = STAT_DONE;
              end else begin
                st_nxt    = STAT_NOCHG;
              end
              state_nxt = S_RESP;
            end else begin
              rd_en   = 1'b1;
              idx_nxt = idx_r + AW'(1);
            end
          end
          default: begin
            // Membership test
            st_nxt = STAT_DONE;
            if (eq || gt || is_last) begin
              hit_nxt   = eq;
              state_nxt = S_RESP;
            end else begin
              rd_en   = 1'b1;
              idx_nxt = idx_r + AW'(1);
            end
          end
        endcase
      end

      S_TAIL: begin
        // Write the displaced top entry one past the old end
        wr_en     = 1'b1;
        wr_addr   = count_r[AW-1:0];
        wr_data   = carry_r;
        count_nxt = count_r + CW'(1);
        st_nxt    = STAT_DONE;
        state_nxt = S_RESP;
      end

      S_LIST: begin
        if (out_free) begin
          ld          = 1'b1;
          res.status  = STAT_DONE;
          res.data    = rd_sx[31:0];
          res.last    = single_r || is_last;
          if (single_r || is_last) begin
            state_nxt = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            idx_nxt = idx_r + AW'(1);
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          ld         = 1'b1;
          res.status = st_r;
          res.hit    = hit_r;
          res.last   = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    flag_r   <= flag_nxt;
    single_r <= single_nxt;
    func_r   <= func_nxt;
    e_r      <= e_nxt;
    carry_r  <= carry_nxt;
    st_r     <= st_nxt;
    hit_r    <= hit_nxt;
  end

endmodule

`default_nettype wire

// ----- src/sorted_set_table_core.sv -----
// Sorted set table: a set of distinct signed elements kept in ascending
// order in a single-port-read, single-port-write memory of CAPACITY entries.
// Add, remove and test scan the store from the smallest entry, one entry
// per cycle through the memory read port, and stop at the first entry not
// less than the operand; add and remove shift the entries behind it in the
// same pass; an add that succeeds on a set that is not empty then writes
// the displaced top entry one past the old end. Read smallest returns the
// first entry as its only result; a listing gives one result per cycle
// once the first entry is read, and slows only when the consumer stalls.
// Items are taken one at a time: in_stall is high from the transfer of an
// item until its last result sits in the output register.
// Depends on sst_pkg, sst_mem, sst_out and sst_seq.
`timescale 1ns / 1ps
`default_nettype none

module sorted_set_table_core
  import sst_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire sst_in_t in_item,
  output logic         out_valid,
  input  wire logic    out_stall,
  output sst_out_t     out_item
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [ELEM_WIDTH-1:0] rd_data;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [ELEM_WIDTH-1:0] wr_data;
  logic                  out_free;
  logic                  ld;
  sst_out_t              res;

  sst_mem #(
    .DEPTH (CAPACITY),
    .EW    (ELEM_WIDTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  sst_seq #(
    .CAPACITY (CAPACITY),
    .EW       (ELEM_WIDTH),
    .AW       (AW),
    .CW       (CW)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .out_free (out_free),
    .ld       (ld),
    .res      (res)
  );

  sst_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld        (ld),
    .res       (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // One item at a time: a transfer closes the input until its results go out
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input transfer taken while an item is in flight");

  // An empty-set result is the only result of its item
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == STAT_EMPTY) |-> (out_item.is_empty && out_item.last))
    else $error("empty status without empty flag or last mark");

  // A hit comes only from a completed membership test
  a_hit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.hit) |-> (out_item.status == STAT_DONE && out_item.last))
    else $error("hit reported on a result that is not a test answer");

  // The empty flag agrees with the reported count
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.is_empty) |-> (out_item.count == 5'd0))
    else $error("empty flag with nonzero count");

endmodule

`default_nettype wire
